// ----- rtl/tkh_pkg.sv -----
package tkh_pkg;

  localparam int CAPACITY = 16;
  localparam int MAX_KEYS = 4;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 16;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KSEL_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KCNT_W = $clog2(MAX_KEYS + 1);

  typedef enum logic [1:0] {
    REQ_OFFER = 2'd0,
    REQ_DRAIN = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_KEYS   = 2'd1,
    CFG_ASC    = 2'd2,
    CFG_NULLS  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PL_DEFAULT = 2'd0,
    PL_FIRST   = 2'd1,
    PL_LAST    = 2'd2,
    PL_UNUSED  = 2'd3
  } null_pl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFER_RD,
    ST_OFFER_CMP,
    ST_WRITE,
    ST_RISE_RD,
    ST_RISE_CMP,
    ST_FALL_RD,
    ST_FALL_LR,
    ST_FALL_CMP,
    ST_POP,
    ST_EMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [KCNT_W-1:0]   keys_used;
    logic [MAX_KEYS-1:0] asc;
    logic [2*MAX_KEYS-1:0] placement;
  } cmp_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic less;
    logic greater;
  } cmp_stat_t;

endpackage

// ----- rtl/tkh_key_cmp.sv -----
module tkh_key_cmp (
  input  logic                              clk,
  input  logic                              rst,
  input  tkh_pkg::cmp_cfg_t                 cfg,
  input  logic                              start,
  input  logic [tkh_pkg::MAX_KEYS*tkh_pkg::KEY_WIDTH-1:0] a_keys,
  input  logic [tkh_pkg::MAX_KEYS-1:0]      a_nulls,
  input  logic [tkh_pkg::MAX_KEYS*tkh_pkg::KEY_WIDTH-1:0] b_keys,
  input  logic [tkh_pkg::MAX_KEYS-1:0]      b_nulls,
  output tkh_pkg::cmp_stat_t                stat
);

  logic                      busy;
  logic [tkh_pkg::KCNT_W-1:0] idx;
  logic                      done;
  logic                      less;
  logic                      greater;
  logic [tkh_pkg::KSEL_W-1:0] sel;
  logic signed [tkh_pkg::KEY_WIDTH-1:0] ka;
  logic signed [tkh_pkg::KEY_WIDTH-1:0] kb;
  logic                      an;
  logic                      bn;
  logic                      asc;
  logic                      first;
  logic [1:0]                pl;
  logic                      step_lt;
  logic                      step_gt;
  logic                      last_key;

  assign sel = idx[tkh_pkg::KSEL_W-1:0];
  assign ka = a_keys[sel*tkh_pkg::KEY_WIDTH +: tkh_pkg::KEY_WIDTH];
  assign kb = b_keys[sel*tkh_pkg::KEY_WIDTH +: tkh_pkg::KEY_WIDTH];
  assign an = a_nulls[sel];
  assign bn = b_nulls[sel];
  assign asc = cfg.asc[sel];
  assign pl = cfg.placement[2*sel +: 2];
  assign last_key = (idx + tkh_pkg::KCNT_W'(1)) >= cfg.keys_used;

  always_comb begin
    first = asc;
    if (pl == tkh_pkg::PL_FIRST) begin
      first = 1'b1;
    end else if (pl == tkh_pkg::PL_LAST) begin
      first = 1'b0;
    end
    step_lt = 1'b0;
    step_gt = 1'b0;
    if (an && bn) begin
      step_lt = 1'b0;
    end else if (an) begin
      step_lt = first;
      step_gt = !first;
    end else if (bn) begin
      step_lt = !first;
      step_gt = first;
    end else if (ka != kb) begin
      step_lt = (ka < kb) ? asc : !asc;
      step_gt = !step_lt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx <= '0;
      less <= 1'b0;
      greater <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (busy) begin
        if (step_lt || step_gt || last_key) begin
          busy <= 1'b0;
          done <= 1'b1;
          less <= step_lt;
          greater <= step_gt;
        end else begin
          idx <= idx + tkh_pkg::KCNT_W'(1);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.less = less;
  assign stat.greater = greater;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("compare done without work");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(less && greater)) else $error("compare both ways");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < tkh_pkg::KCNT_W'(tkh_pkg::MAX_KEYS)) else $error("key index out of range");

endmodule

// ----- rtl/top_k_heap_selector.sv -----
// Top-k heap selector. Keeps the best window_size rows (1..16) of a stream under a
// multi-key ordering with per-key direction and null placement; ties go to the earlier
// arrival. Rows live in a 16-entry max-heap whose root is the worst kept row. One
// shared key comparator walks the keys one per cycle. A sift-up level makes one compare,
// a sift-down level one compare with one child and two with two; an offer to a full
// heap first compares the row with the root. A drain pops every row with a sift-down
// per pop, then delivers one transaction per row, one per cycle after the first while
// out_stall is low. Clear and unused requests go straight to the result. in_stall is
// high while a request is in work.
module top_k_heap_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] row_tag,
  input  logic signed [31:0] key_zero,
  input  logic signed [31:0] key_one,
  input  logic signed [31:0] key_two,
  input  logic signed [31:0] key_three,
  input  logic [3:0]  key_null_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        row_valid,
  output logic [15:0] row_tag_out,
  output logic        last_result,
  output logic        kept,
  output logic [4:0]  stored_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int KW = tkh_pkg::KEY_WIDTH;
  localparam int NK = tkh_pkg::MAX_KEYS;
  localparam int SW = tkh_pkg::SLOT_W;
  localparam int CW = tkh_pkg::CNT_W;
  localparam int RW = NK * KW;
  localparam int TAG_W_L = tkh_pkg::TAG_WIDTH;

  logic [4:0] window_size;
  logic [2:0] keys_used;
  logic [3:0] ascending_mask;
  logic [7:0] null_placement;

  logic [SW-1:0] heap_slots [tkh_pkg::CAPACITY];
  logic [RW-1:0] entry_keys [tkh_pkg::CAPACITY];
  logic [NK-1:0] entry_nulls [tkh_pkg::CAPACITY];
  logic [31:0]   entry_ordinal [tkh_pkg::CAPACITY];
  logic [TAG_W_L-1:0] entry_tags [tkh_pkg::CAPACITY];

  logic [CW-1:0] held_count;
  logic [31:0]   arrival_counter;

  tkh_pkg::state_t state;
  tkh_pkg::state_t state_next;

  logic [1:0]    req;
  logic [RW-1:0] new_keys;
  logic [NK-1:0] new_nulls;
  logic [15:0]   new_tag;
  logic [SW-1:0] pos;
  logic [SW-1:0] child;
  logic [SW-1:0] slot_a;
  logic [SW-1:0] slot_b;
  logic [RW-1:0] a_keys;
  logic [NK-1:0] a_nulls;
  logic [31:0]   a_ord;
  logic [RW-1:0] b_keys;
  logic [NK-1:0] b_nulls;
  logic [31:0]   b_ord;
  logic [SW-1:0] order [tkh_pkg::CAPACITY];
  logic [CW-1:0] drain_n;
  logic [CW-1:0] emit_i;

  tkh_pkg::cmp_cfg_t  ccfg;
  tkh_pkg::cmp_stat_t cst;
  logic               cstart;
  logic               a_lt_b;
  logic               a_gt_b;

  logic [CW-1:0] eff_window;
  logic [2:0]    eff_keys;

  logic [CW:0]   lidx;
  logic [CW:0]   ridx;
  logic          out_fire;
  logic          in_fire;
  logic          out_load;
  logic          offered_kept;

  always_comb begin
    eff_window = (window_size == 5'd0) ? CW'(1) :
                 (window_size > 5'(tkh_pkg::CAPACITY)) ? CW'(tkh_pkg::CAPACITY) :
                 CW'(window_size);
    eff_keys = (keys_used == 3'd0) ? 3'd1 : (keys_used > 3'(NK)) ? 3'(NK) : keys_used;
  end

  assign ccfg.keys_used = tkh_pkg::KCNT_W'(eff_keys);
  assign ccfg.asc = ascending_mask;
  assign ccfg.placement = null_placement;

  tkh_key_cmp u_cmp (
    .clk(clk), .rst(rst), .cfg(ccfg), .start(cstart),
    .a_keys(a_keys), .a_nulls(a_nulls), .b_keys(b_keys), .b_nulls(b_nulls),
    .stat(cst)
  );

  // full order including arrival tie break
  always_comb begin
    a_lt_b = cst.less || (!cst.greater && (a_ord < b_ord));
    a_gt_b = cst.greater || (!cst.less && (a_ord > b_ord));
  end

  assign in_stall = (state != tkh_pkg::ST_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign cfg_ready = (state == tkh_pkg::ST_IDLE);
  assign lidx = {1'b0, pos, 1'b1};
  assign ridx = {1'b0, pos, 1'b0} + (CW+1)'(2);
  assign out_load = ((state == tkh_pkg::ST_EMIT) && (!out_valid || out_fire) &&
                     !(out_fire && last_result)) ||
                    ((state == tkh_pkg::ST_RESULT) && !out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 5'd16;
      keys_used <= 3'd1;
      ascending_mask <= 4'hf;
      null_placement <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tkh_pkg::cfg_idx_t'(cfg_index))
        tkh_pkg::CFG_WINDOW: window_size <= cfg_data[4:0];
        tkh_pkg::CFG_KEYS:   keys_used <= cfg_data[2:0];
        tkh_pkg::CFG_ASC:    ascending_mask <= cfg_data[3:0];
        tkh_pkg::CFG_NULLS:  null_placement <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tkh_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (req_type == tkh_pkg::REQ_OFFER) begin
            state_next = tkh_pkg::ST_OFFER_RD;
          end else if (req_type == tkh_pkg::REQ_DRAIN && held_count != '0) begin
            state_next = tkh_pkg::ST_POP;
          end else begin
            state_next = tkh_pkg::ST_RESULT;
          end
        end
      end
      tkh_pkg::ST_OFFER_RD: begin
        state_next = (held_count < eff_window) ? tkh_pkg::ST_WRITE : tkh_pkg::ST_OFFER_CMP;
      end
      tkh_pkg::ST_OFFER_CMP: begin
        if (cst.done) begin
          state_next = cst.less ? tkh_pkg::ST_WRITE : tkh_pkg::ST_RESULT;
        end
      end
      tkh_pkg::ST_WRITE: begin
        state_next = (held_count < eff_window) ? tkh_pkg::ST_RISE_RD : tkh_pkg::ST_FALL_RD;
      end
      tkh_pkg::ST_RISE_RD: begin
        state_next = (pos == '0) ? tkh_pkg::ST_RESULT : tkh_pkg::ST_RISE_CMP;
      end
      tkh_pkg::ST_RISE_CMP: begin
        if (cst.done) begin
          state_next = a_lt_b ? tkh_pkg::ST_RISE_RD : tkh_pkg::ST_RESULT;
        end
      end
      tkh_pkg::ST_FALL_RD: begin
        if (lidx >= (CW+1)'(held_count)) begin
          state_next = (req == tkh_pkg::REQ_DRAIN) ? tkh_pkg::ST_POP : tkh_pkg::ST_RESULT;
        end else if (ridx < (CW+1)'(held_count)) begin
          state_next = tkh_pkg::ST_FALL_LR;
        end else begin
          state_next = tkh_pkg::ST_FALL_CMP;
        end
      end
      tkh_pkg::ST_FALL_LR: begin
        if (cst.done) begin
          state_next = tkh_pkg::ST_FALL_CMP;
        end
      end
      tkh_pkg::ST_FALL_CMP: begin
        if (cst.done) begin
          if (a_lt_b) begin
            state_next = tkh_pkg::ST_FALL_RD;
          end else begin
            state_next = (req == tkh_pkg::REQ_DRAIN) ? tkh_pkg::ST_POP : tkh_pkg::ST_RESULT;
          end
        end
      end
      tkh_pkg::ST_POP: begin
        state_next = (held_count == CW'(1)) ? tkh_pkg::ST_EMIT : tkh_pkg::ST_FALL_RD;
      end
      tkh_pkg::ST_EMIT: begin
        if (out_fire && last_result) begin
          state_next = tkh_pkg::ST_IDLE;
        end
      end
      tkh_pkg::ST_RESULT: begin
        if (out_fire) begin
          state_next = tkh_pkg::ST_IDLE;
        end
      end
      default: state_next = tkh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cstart = 1'b0;
    unique case (state)
      tkh_pkg::ST_OFFER_RD:  cstart = !(held_count < eff_window);
      tkh_pkg::ST_RISE_RD:   cstart = (pos != '0);
      tkh_pkg::ST_FALL_RD:   cstart = (lidx < (CW+1)'(held_count));
      tkh_pkg::ST_FALL_LR:   cstart = cst.done;
      default:               cstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // datapath, operands staged for the shared comparator
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      arrival_counter <= '0;
      emit_i <= '0;
    end else begin
      unique case (state)
        tkh_pkg::ST_IDLE: begin
          if (in_fire) begin
            req <= req_type;
            new_keys <= {key_three, key_two, key_one, key_zero};
            new_nulls <= key_null_mask;
            new_tag <= row_tag;
            drain_n <= held_count;
            if (req_type == tkh_pkg::REQ_CLEAR) begin
              held_count <= '0;
              arrival_counter <= '0;
            end
          end
        end
        tkh_pkg::ST_OFFER_RD: begin
          a_keys <= new_keys;
          a_nulls <= new_nulls;
          b_keys <= entry_keys[heap_slots[0]];
          b_nulls <= entry_nulls[heap_slots[0]];
        end
        tkh_pkg::ST_OFFER_CMP: ;
        tkh_pkg::ST_WRITE: begin
          if (held_count < eff_window) begin
            pos <= SW'(held_count);
            heap_slots[SW'(held_count)] <= SW'(held_count);
            entry_keys[SW'(held_count)] <= new_keys;
            entry_nulls[SW'(held_count)] <= new_nulls;
            entry_ordinal[SW'(held_count)] <= arrival_counter;
            entry_tags[SW'(held_count)] <= new_tag;
            held_count <= held_count + CW'(1);
          end else begin
            pos <= '0;
            entry_keys[heap_slots[0]] <= new_keys;
            entry_nulls[heap_slots[0]] <= new_nulls;
            entry_ordinal[heap_slots[0]] <= arrival_counter;
            entry_tags[heap_slots[0]] <= new_tag;
          end
          arrival_counter <= arrival_counter + 32'd1;
        end
        tkh_pkg::ST_RISE_RD: begin
          slot_a <= heap_slots[(pos - SW'(1)) >> 1];
          slot_b <= heap_slots[pos];
          a_keys <= entry_keys[heap_slots[(pos - SW'(1)) >> 1]];
          a_nulls <= entry_nulls[heap_slots[(pos - SW'(1)) >> 1]];
          a_ord <= entry_ordinal[heap_slots[(pos - SW'(1)) >> 1]];
          b_keys <= entry_keys[heap_slots[pos]];
          b_nulls <= entry_nulls[heap_slots[pos]];
          b_ord <= entry_ordinal[heap_slots[pos]];
        end
        tkh_pkg::ST_RISE_CMP: begin
          if (cst.done && a_lt_b) begin
            heap_slots[(pos - SW'(1)) >> 1] <= slot_b;
            heap_slots[pos] <= slot_a;
            pos <= (pos - SW'(1)) >> 1;
          end
        end
        tkh_pkg::ST_FALL_RD: begin
          child <= lidx[SW-1:0];
          // left vs right first when both exist, else node vs left
          if (ridx < (CW+1)'(held_count)) begin
            a_keys <= entry_keys[heap_slots[lidx[SW-1:0]]];
            a_nulls <= entry_nulls[heap_slots[lidx[SW-1:0]]];
            a_ord <= entry_ordinal[heap_slots[lidx[SW-1:0]]];
            b_keys <= entry_keys[heap_slots[ridx[SW-1:0]]];
            b_nulls <= entry_nulls[heap_slots[ridx[SW-1:0]]];
            b_ord <= entry_ordinal[heap_slots[ridx[SW-1:0]]];
          end else begin
            a_keys <= entry_keys[heap_slots[pos]];
            a_nulls <= entry_nulls[heap_slots[pos]];
            a_ord <= entry_ordinal[heap_slots[pos]];
            b_keys <= entry_keys[heap_slots[lidx[SW-1:0]]];
            b_nulls <= entry_nulls[heap_slots[lidx[SW-1:0]]];
            b_ord <= entry_ordinal[heap_slots[lidx[SW-1:0]]];
          end
        end
        tkh_pkg::ST_FALL_LR: begin
          if (cst.done) begin
            a_keys <= entry_keys[heap_slots[pos]];
            a_nulls <= entry_nulls[heap_slots[pos]];
            a_ord <= entry_ordinal[heap_slots[pos]];
            if (a_lt_b) begin
              child <= ridx[SW-1:0];
              b_keys <= entry_keys[heap_slots[ridx[SW-1:0]]];
              b_nulls <= entry_nulls[heap_slots[ridx[SW-1:0]]];
              b_ord <= entry_ordinal[heap_slots[ridx[SW-1:0]]];
            end else begin
              b_keys <= entry_keys[heap_slots[lidx[SW-1:0]]];
              b_nulls <= entry_nulls[heap_slots[lidx[SW-1:0]]];
              b_ord <= entry_ordinal[heap_slots[lidx[SW-1:0]]];
            end
          end
        end
        tkh_pkg::ST_FALL_CMP: begin
          if (cst.done && a_lt_b) begin
            heap_slots[pos] <= heap_slots[child];
            heap_slots[child] <= heap_slots[pos];
            pos <= child;
          end
        end
        tkh_pkg::ST_POP: begin
          order[SW'(held_count - CW'(1))] <= heap_slots[0];
          heap_slots[0] <= heap_slots[SW'(held_count - CW'(1))];
          held_count <= held_count - CW'(1);
          pos <= '0;
          if (held_count == CW'(1)) begin
            emit_i <= '0;
          end
        end
        tkh_pkg::ST_EMIT: begin
          if (out_load) begin
            row_valid <= 1'b1;
            row_tag_out <= entry_tags[order[SW'(emit_i)]];
            last_result <= (emit_i + CW'(1) == drain_n);
            kept <= 1'b0;
            stored_count <= 5'd0;
            emit_i <= emit_i + CW'(1);
          end
        end
        tkh_pkg::ST_RESULT: begin
          if (out_load) begin
            row_valid <= 1'b0;
            row_tag_out <= '0;
            last_result <= 1'b1;
            kept <= (req == tkh_pkg::REQ_OFFER) && offered_kept;
            stored_count <= 5'(held_count);
          end
        end
        default: ;
      endcase
    end
  end

  // an offer reaches the result state through a write only when kept
  always_ff @(posedge clk) begin
    if (rst) begin
      offered_kept <= 1'b0;
    end else if (state == tkh_pkg::ST_IDLE) begin
      offered_kept <= 1'b0;
    end else if (state == tkh_pkg::ST_WRITE) begin
      offered_kept <= 1'b1;
    end
  end

  a_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(tkh_pkg::CAPACITY)) else $error("held count over capacity");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result pending while idle");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(in_fire) && $past(req_type) == tkh_pkg::REQ_CLEAR |-> held_count == '0)
    else $error("clear left rows");
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_valid |-> held_count == '0) else $error("emit before heap empty");

endmodule
